### hw/rtl/ole_pkg.sv
`default_nettype none

package ole_pkg;

	// field widths of the request and response payloads
	localparam int CMD_W = 3;
	localparam int VAL_W = 32;
	localparam int POS_W = 6;
	localparam int ST_W  = 3;

	typedef enum logic [CMD_W-1:0] {
		CMD_APPEND  = 3'd0,
		CMD_PREPEND = 3'd1,
		CMD_INSERT  = 3'd2,
		CMD_DUMP    = 3'd3,
		CMD_DELETE  = 3'd4,
		CMD_READ    = 3'd5,
		CMD_CLEAR   = 3'd6
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK       = 3'd0,
		ST_EMPTY    = 3'd1,
		ST_BADPOS   = 3'd2,
		ST_NOTFOUND = 3'd3,
		ST_FULL     = 3'd4
	} status_t;

endpackage

`default_nettype wire

### hw/rtl/ole_req_if.sv
`default_nettype none

interface ole_req_if import ole_pkg::*; ();
	logic                    valid;
	logic                    ready;
	logic [CMD_W-1:0]        command;
	logic signed [VAL_W-1:0] value;
	logic [POS_W-1:0]        position;

	modport source (output valid, output command, output value, output position, input ready);
	modport sink   (input valid, input command, input value, input position, output ready);
endinterface

`default_nettype wire

### hw/rtl/ole_rsp_if.sv
`default_nettype none

interface ole_rsp_if import ole_pkg::*; ();
	logic                    valid;
	logic                    ready;
	status_t                 status;
	logic signed [VAL_W-1:0] entry_value;
	logic                    last;

	modport source (output valid, output status, output entry_value, output last, input ready);
	modport sink   (input valid, input status, input entry_value, input last, output ready);
endinterface

`default_nettype wire

### hw/rtl/ole_ram.sv
`default_nettype none

module ole_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// one write port, one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

### hw/rtl/ordered_list_engine_top.sv
`default_nettype none

// channel  modport  payload                               one request is
// req      sink     command, value, position              one list command
// rsp      source   status, entry_value, last             one result item
//
// work: append, prepend and insert move entries up to open the slot, one entry moved
//   per cycle through the single ram port pair; delete searches for the first match,
//   then shifts the entries behind it down; read fetches one entry; dump streams each entry
// reset: arst_n clears the entry count and the controller; ram contents stay undefined
//   and are only read below the count, so no clearing pass is run
// stalls: req is taken only while the controller is idle; a result waits in the
//   output register, and a new request may be taken while it waits

module ordered_list_engine_top import ole_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	ole_req_if.sink    req,
	ole_rsp_if.source  rsp
);

	localparam int IW   = $clog2(CAPACITY);
	localparam int CW   = $clog2(CAPACITY + 1);
	localparam int CMPW = (CW > POS_W) ? CW : POS_W;

	typedef enum logic [2:0] {
		S_IDLE,
		S_SHIFT,   // open a slot, moving entries up from the back
		S_PLACE,   // write the new entry into the open slot
		S_SEARCH,  // scan for the first matching entry
		S_DSHIFT,  // close the gap, moving entries down
		S_DUMP,    // stream every entry out
		S_READ,    // fetch one entry
		S_RESP     // hand a single final result to the output register
	} state_t;

	state_t                  state_q;
	logic [CW-1:0]           count_q;
	logic [CW-1:0]           cur_q;    // working cursor
	logic [CW-1:0]           at_q;     // slot for an insert
	logic signed [VAL_W-1:0] val_q;
	status_t                 st_q;
	logic signed [VAL_W-1:0] ent_q;

	// read-to-write pipeline of the shift, and read-to-use of search, dump and read
	logic                    pend_s1;
	logic [IW-1:0]           wa_s1;
	logic                    rv_s1;
	logic [IW-1:0]           ri_s1;

	// output register
	logic                    out_valid_q;
	status_t                 out_status_q;
	logic signed [VAL_W-1:0] out_value_q;
	logic                    out_last_q;

	logic [VAL_W-1:0]        rd_data;
	logic [IW-1:0]           raddr;
	logic                    we;
	logic [IW-1:0]           waddr;
	logic [VAL_W-1:0]        wdata;
	logic [CW-1:0]           cur_m1;
	logic [CMPW-1:0]         pos_x;
	logic [CMPW-1:0]         cnt_x;
	logic                    full;
	logic                    can_emit;
	logic                    accept;
	logic                    pos_ok;

	assign req.ready   = (state_q == S_IDLE);
	assign accept      = req.valid && req.ready;
	assign rsp.valid   = out_valid_q;
	assign rsp.status  = out_status_q;
	assign rsp.entry_value = out_value_q;
	assign rsp.last    = out_last_q;

	assign can_emit = !out_valid_q || rsp.ready;
	assign full     = (count_q == CW'(CAPACITY));
	assign pos_x    = CMPW'(req.position);
	assign cnt_x    = CMPW'(count_q);
	// position one is always fine, two up to the count as well
	assign pos_ok   = (pos_x == CMPW'(1)) || ((pos_x >= CMPW'(2)) && (pos_x <= cnt_x));
	assign cur_m1   = cur_q - CW'(1);

	// the shift reads one below the cursor, everything else at the cursor
	assign raddr = (state_q == S_SHIFT) ? cur_m1[IW-1:0] : cur_q[IW-1:0];
	assign we    = pend_s1 || (state_q == S_PLACE);
	assign waddr = (state_q == S_PLACE) ? at_q[IW-1:0] : wa_s1;
	assign wdata = (state_q == S_PLACE) ? val_q : rd_data;

	ole_ram #(
		.WIDTH (VAL_W),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			count_q      <= '0;
			cur_q        <= '0;
			at_q         <= '0;
			val_q        <= '0;
			st_q         <= ST_OK;
			ent_q        <= '0;
			pend_s1      <= 1'b0;
			wa_s1        <= '0;
			rv_s1        <= 1'b0;
			ri_s1        <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= ST_OK;
			out_value_q  <= '0;
			out_last_q   <= 1'b0;
		end else begin
			pend_s1 <= 1'b0;
			if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						val_q <= req.value;
						ent_q <= '0;
						rv_s1 <= 1'b0;
						unique case (req.command)
							CMD_APPEND, CMD_PREPEND: begin
								if (full) begin
									st_q    <= ST_FULL;
									state_q <= S_RESP;
								end else begin
									at_q    <= (req.command == CMD_APPEND) ? count_q : '0;
									cur_q   <= count_q;
									state_q <= S_SHIFT;
								end
							end
							CMD_INSERT: begin
								if (!pos_ok) begin
									st_q    <= ST_BADPOS;
									state_q <= S_RESP;
								end else if (full) begin
									st_q    <= ST_FULL;
									state_q <= S_RESP;
								end else begin
									at_q    <= CW'(pos_x - CMPW'(1));
									cur_q   <= count_q;
									state_q <= S_SHIFT;
								end
							end
							CMD_DUMP: begin
								cur_q <= '0;
								if (count_q == '0) begin
									st_q    <= ST_EMPTY;
									state_q <= S_RESP;
								end else begin
									state_q <= S_DUMP;
								end
							end
							CMD_DELETE: begin
								cur_q <= '0;
								if (count_q == '0) begin
									st_q    <= ST_NOTFOUND;
									state_q <= S_RESP;
								end else begin
									state_q <= S_SEARCH;
								end
							end
							CMD_READ: begin
								if (count_q == '0) begin
									st_q    <= ST_EMPTY;
									state_q <= S_RESP;
								end else if (pos_x >= cnt_x) begin
									st_q    <= ST_BADPOS;
									state_q <= S_RESP;
								end else begin
									cur_q   <= CW'(pos_x);
									state_q <= S_READ;
								end
							end
							CMD_CLEAR: begin
								count_q <= '0;
								st_q    <= ST_OK;
								state_q <= S_RESP;
							end
							default: begin
								// unused code: dropped without a result
								state_q <= S_IDLE;
							end
						endcase
					end
				end

				S_SHIFT: begin
					if (cur_q > at_q) begin
						pend_s1 <= 1'b1;
						wa_s1   <= cur_q[IW-1:0];
						cur_q   <= cur_m1;
					end else begin
						state_q <= S_PLACE;
					end
				end

				S_PLACE: begin
					count_q <= count_q + CW'(1);
					st_q    <= ST_OK;
					state_q <= S_RESP;
				end

				S_SEARCH: begin
					if (rv_s1 && (rd_data == val_q)) begin
						rv_s1   <= 1'b0;
						cur_q   <= CW'(ri_s1) + CW'(1);
						state_q <= S_DSHIFT;
					end else if (cur_q < count_q) begin
						rv_s1 <= 1'b1;
						ri_s1 <= cur_q[IW-1:0];
						cur_q <= cur_q + CW'(1);
					end else begin
						rv_s1   <= 1'b0;
						st_q    <= ST_NOTFOUND;
						state_q <= S_RESP;
					end
				end

				S_DSHIFT: begin
					if (cur_q < count_q) begin
						pend_s1 <= 1'b1;
						wa_s1   <= cur_m1[IW-1:0];
						cur_q   <= cur_q + CW'(1);
					end else begin
						// the last move is written back in this cycle
						count_q <= count_q - CW'(1);
						st_q    <= ST_OK;
						state_q <= S_RESP;
					end
				end

				S_DUMP: begin
					if (!rv_s1) begin
						rv_s1 <= 1'b1;
					end else if (can_emit) begin
						out_valid_q  <= 1'b1;
						out_status_q <= ST_OK;
						out_value_q  <= rd_data;
						out_last_q   <= (cur_q == count_q - CW'(1));
						rv_s1        <= 1'b0;
						cur_q        <= cur_q + CW'(1);
						if (cur_q == count_q - CW'(1)) begin
							state_q <= S_IDLE;
						end
					end
				end

				S_READ: begin
					if (!rv_s1) begin
						rv_s1 <= 1'b1;
					end else begin
						rv_s1   <= 1'b0;
						ent_q   <= rd_data;
						st_q    <= ST_OK;
						state_q <= S_RESP;
					end
				end

				S_RESP: begin
					if (can_emit) begin
						out_valid_q  <= 1'b1;
						out_status_q <= st_q;
						out_value_q  <= ent_q;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// a pending move is only ever launched by one of the two shift loops
	assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> $past(state_q == S_SHIFT || state_q == S_DSHIFT))
		else $error("shift write without a shift read");

	// the new entry never collides with a move on the single write port
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE) |-> !pend_s1)
		else $error("write port conflict");

	// placing an entry grows the list by exactly one
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PLACE) |=> (count_q == CW'($past(count_q) + CW'(1))))
		else $error("count not advanced by insert");

	// the list never holds more than its capacity
	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("count beyond capacity");

endmodule

`default_nettype wire

### tb/ole_list_checker.sv
`default_nettype none

module ole_list_checker import ole_pkg::*; #(
	parameter int CAPACITY = 32
) (
	input  wire logic clk,
	input  wire logic arst_n,
	ole_req_if        req_mon,
	ole_rsp_if        rsp_mon,
	output int        failures,
	output int        pending
);

	typedef struct {
		status_t                 status;
		logic signed [VAL_W-1:0] entry_value;
		logic                    last;
	} list_result_t;

	list_result_t            awaited_results[$];
	logic signed [VAL_W-1:0] list_vals [CAPACITY];
	int                      list_len       = 0;
	int                      mismatch_tally = 0;

	function automatic void await_result(status_t st, logic signed [VAL_W-1:0] v, logic fin);
		list_result_t r;
		r.status      = st;
		r.entry_value = v;
		r.last        = fin;
		awaited_results.push_back(r);
	endfunction

	function automatic void open_slot(int slot, logic signed [VAL_W-1:0] v);
		for (int i = list_len; i > slot; i--)
			list_vals[i] = list_vals[i-1];
		list_vals[slot] = v;
		list_len++;
	endfunction

	function automatic void flag_mismatch(string what, logic signed [VAL_W-1:0] want,
			logic signed [VAL_W-1:0] got);
		mismatch_tally++;
		$display("%0t: %s expected %0d, got %0d", $time, what, want, got);
	endfunction

	// list update for one accepted request, with the results it should give
	function automatic void step_list(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] v,
			logic [POS_W-1:0] p);
		int hit;
		hit = -1;
		case (cmd)
			CMD_APPEND, CMD_PREPEND: begin
				if (list_len >= CAPACITY) begin
					await_result(ST_FULL, '0, 1'b1);
				end else begin
					open_slot((cmd == CMD_APPEND) ? list_len : 0, v);
					await_result(ST_OK, '0, 1'b1);
				end
			end
			CMD_INSERT: begin
				if (!(int'(p) == 1 || (int'(p) >= 2 && int'(p) <= list_len))) begin
					await_result(ST_BADPOS, '0, 1'b1);
				end else if (list_len >= CAPACITY) begin
					await_result(ST_FULL, '0, 1'b1);
				end else begin
					open_slot(int'(p) - 1, v);
					await_result(ST_OK, '0, 1'b1);
				end
			end
			CMD_DUMP: begin
				if (list_len == 0)
					await_result(ST_EMPTY, '0, 1'b1);
				for (int i = 0; i < list_len; i++)
					await_result(ST_OK, list_vals[i], i == list_len - 1);
			end
			CMD_DELETE: begin
				for (int i = 0; i < list_len; i++)
					if (hit < 0 && list_vals[i] == v)
						hit = i;
				if (hit < 0) begin
					await_result(ST_NOTFOUND, '0, 1'b1);
				end else begin
					for (int i = hit; i + 1 < list_len; i++)
						list_vals[i] = list_vals[i+1];
					list_len--;
					await_result(ST_OK, '0, 1'b1);
				end
			end
			CMD_READ: begin
				if (list_len == 0)
					await_result(ST_EMPTY, '0, 1'b1);
				else if (int'(p) >= list_len)
					await_result(ST_BADPOS, '0, 1'b1);
				else
					await_result(ST_OK, list_vals[p], 1'b1);
			end
			CMD_CLEAR: begin
				list_len = 0;
				await_result(ST_OK, '0, 1'b1);
			end
			default: begin
				// unused code: no result, list untouched
			end
		endcase
	endfunction

	always @(posedge clk or negedge arst_n) begin
		list_result_t want;
		if (!arst_n) begin
			awaited_results.delete();
			list_len = 0;
		end else begin
			// results first: a request taken at this edge cannot answer at the same edge
			if (rsp_mon.valid && rsp_mon.ready) begin
				if (awaited_results.size() == 0) begin
					flag_mismatch("unawaited result, status", 'x, rsp_mon.status);
				end else begin
					want = awaited_results.pop_front();
					if (rsp_mon.status !== want.status)
						flag_mismatch("status", want.status, rsp_mon.status);
					if (rsp_mon.entry_value !== want.entry_value)
						flag_mismatch("entry_value", want.entry_value, rsp_mon.entry_value);
					if (rsp_mon.last !== want.last)
						flag_mismatch("last", want.last, rsp_mon.last);
				end
			end
			if (req_mon.valid && req_mon.ready)
				step_list(req_mon.command, req_mon.value, req_mon.position);
		end
		failures <= mismatch_tally;
		pending  <= awaited_results.size();
	end

endmodule

`default_nettype wire

### tb/tb_ordered_list_engine_top.sv
`default_nettype none

// request stimulus and verdict for the ordered list engine; all checking sits in
// the checker beside the block
module tb_ordered_list_engine_top;
	import ole_pkg::*;

	localparam int CAPACITY = 32;

	// slowest correct item: a full dump, each result held up by the random
	// back-pressure, plus the sender's gap; some 310 requests in all, so the limit
	// leaves a wide margin
	localparam int CYCLE_LIMIT   = 400000;
	// longest internal work with no result pending: a delete searching and
	// shifting a full list
	localparam int SETTLE_CYCLES = 150;

	localparam int ROUNDS      = 5;
	localparam int FILL_ITEMS  = 44;
	localparam int DRAIN_ITEMS = 11;
	localparam int CALM_ROUND  = 2;

	// code 7 is not a command; the block must swallow it silently
	localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

	localparam logic signed [VAL_W-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VAL_W-1:0] VAL_MAX = 32'sh7fff_ffff;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	logic calm   = 1'b0;
	int   cycle_count = 0;
	int   fail_count;
	int   pending_count;

	// small value pool so deletes find matches and duplicates appear
	logic signed [VAL_W-1:0] value_pool [8];

	ole_req_if req_ch ();
	ole_rsp_if rsp_ch ();

	ordered_list_engine_top #(
		.CAPACITY(CAPACITY)
	) u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch),
		.rsp   (rsp_ch)
	);

	ole_list_checker #(
		.CAPACITY(CAPACITY)
	) u_checker (
		.clk     (clk),
		.arst_n  (arst_n),
		.req_mon (req_ch),
		.rsp_mon (rsp_ch),
		.failures(fail_count),
		.pending (pending_count)
	);

	always #10 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// result back-pressure: about a quarter of cycles stalled, none in the calm round
	always @(posedge clk) begin
		rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 24);
	end

	// one request: optional idle gap first, then hold valid until it is taken
	task automatic send_request(logic [CMD_W-1:0] cmd, logic signed [VAL_W-1:0] v,
			logic [POS_W-1:0] p);
		while (!calm && $urandom_range(0, 99) < 24) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid    <= 1'b1;
		req_ch.command  <= cmd;
		req_ch.value    <= v;
		req_ch.position <= p;
		do
			@(posedge clk);
		while (!req_ch.ready);
	endtask

	function automatic logic signed [VAL_W-1:0] pick_value();
		if ($urandom_range(0, 99) < 60)
			return value_pool[$urandom_range(0, 7)];
		return $urandom;
	endfunction

	// insert position: mostly near the front so it is usually legal, some anywhere
	function automatic logic [POS_W-1:0] pick_slot();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 50)
			return $urandom_range(1, 4);
		if (roll < 80)
			return $urandom_range(1, CAPACITY + 2);
		return $urandom_range(0, 63);
	endfunction

	initial begin
		int roll;
		req_ch.valid    = 1'b0;
		req_ch.command  = CMD_APPEND;
		req_ch.value    = '0;
		req_ch.position = '0;
		value_pool[0] = VAL_MIN;
		value_pool[1] = VAL_MAX;
		value_pool[2] = '0;
		value_pool[3] = -32'sd1;
		for (int i = 4; i < 8; i++)
			value_pool[i] = $urandom;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty-list cases
		send_request(CMD_DUMP,   '0, '0);
		send_request(CMD_READ,   '0, '0);
		send_request(CMD_DELETE, 32'sd5, '0);
		// position 0 and a position past the end are refused
		send_request(CMD_INSERT, 32'sd9, 6'd0);
		send_request(CMD_INSERT, 32'sd9, 6'd2);
		// position 1 is legal on an empty list
		send_request(CMD_INSERT,  VAL_MIN, 6'd1);
		send_request(CMD_APPEND,  VAL_MAX, 6'd63);
		send_request(CMD_PREPEND, '0, '0);
		// insert before the last entry: list is now 0, min, -1, max
		send_request(CMD_INSERT, -32'sd1, 6'd3);
		send_request(CMD_INSERT, 32'sd9, 6'd5);
		send_request(CMD_INSERT, 32'sd9, 6'd63);
		// duplicate of the front value at the tail
		send_request(CMD_APPEND, '0, '0);
		send_request(CMD_READ, '0, 6'd0);
		send_request(CMD_READ, '0, 6'd4);
		send_request(CMD_READ, '0, 6'd5);
		send_request(CMD_READ, '0, 6'd63);
		send_request(CMD_UNUSED, VAL_MAX, 6'd63);
		send_request(CMD_DUMP, '0, '0);
		// delete: front match (first of two), middle, then the tail, then a miss
		send_request(CMD_DELETE, '0, '0);
		send_request(CMD_DELETE, -32'sd1, '0);
		send_request(CMD_DELETE, '0, '0);
		send_request(CMD_DELETE, 32'sd12345, '0);
		send_request(CMD_DUMP,  '0, '0);
		send_request(CMD_CLEAR, '0, '0);
		send_request(CMD_DUMP,  '0, '0);

		// random rounds: clear, fill well past capacity, dump, then mostly deletes
		for (int round = 0; round < ROUNDS; round++) begin
			calm <= (round == CALM_ROUND);
			for (int i = 4; i < 8; i++)
				value_pool[i] = $urandom;
			send_request(CMD_CLEAR, $urandom, $urandom_range(0, 63));

			for (int n = 0; n < FILL_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 40)
					send_request(CMD_APPEND, pick_value(), $urandom_range(0, 63));
				else if (roll < 65)
					send_request(CMD_PREPEND, pick_value(), $urandom_range(0, 63));
				else if (roll < 92)
					send_request(CMD_INSERT, pick_value(), pick_slot());
				else
					send_request($urandom_range(0, 7), $urandom, $urandom_range(0, 63));
			end
			send_request(CMD_DUMP, $urandom, $urandom_range(0, 63));

			for (int n = 0; n < DRAIN_ITEMS; n++) begin
				roll = $urandom_range(0, 99);
				if (roll < 45)
					send_request(CMD_DELETE, value_pool[$urandom_range(0, 7)], '0);
				else if (roll < 55)
					send_request(CMD_DELETE, $urandom, $urandom_range(0, 63));
				else if (roll < 72)
					send_request(CMD_READ, $urandom, $urandom_range(0, CAPACITY + 1));
				else if (roll < 80)
					send_request(CMD_READ, $urandom, $urandom_range(0, 63));
				else if (roll < 88)
					send_request(CMD_DUMP, $urandom, $urandom_range(0, 63));
				else if (roll < 94)
					send_request(CMD_INSERT, pick_value(), pick_slot());
				else if (roll < 98)
					send_request($urandom_range(0, 7), $urandom, $urandom_range(0, 63));
				else
					send_request(CMD_CLEAR, $urandom, $urandom_range(0, 63));
			end
		end

		req_ch.valid <= 1'b0;
		calm         <= 1'b0;
		// let the checker's pending count take in the last request before polling it
		@(posedge clk);
		while (pending_count != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

### sim.f
hw/rtl/ole_pkg.sv
hw/rtl/ole_req_if.sv
hw/rtl/ole_rsp_if.sv
hw/rtl/ole_ram.sv
hw/rtl/ordered_list_engine_top.sv
tb/ole_list_checker.sv
tb/tb_ordered_list_engine_top.sv
